// File: src/ibc_pkg.sv
// Shared constants for the binned interval coverage block.
// No dependencies; imported by interval_bin_coverage and tb.
`timescale 1ns / 1ps

package ibc_pkg;

  // Default storage shape
  localparam int unsigned IBC_NUM_BINS_DEF    = 1024;
  localparam int unsigned IBC_COUNT_WIDTH_DEF = 32;

  // Field widths
  localparam int unsigned BIN_SPAN_W  = 21;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned BIN_IDX_W   = 10;
  localparam int unsigned OUT_COUNT_W = 32;
  localparam int unsigned ADDED_W     = 11;

  // Stream payload widths (padded to whole bytes)
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 48;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BIN_SPAN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ON   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 3'd4;

  // Request kinds
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Register reset values
  localparam logic [BIN_SPAN_W-1:0] BIN_SPAN_RST   = 21'd1000;
  localparam logic [POS_W-1:0]      MAX_LENGTH_RST = 32'hFFFF_FFFF;

endpackage

// File: src/interval_bin_coverage.sv
// Binned interval coverage histogram: counters in one RAM, read-modify-write per bin.
// Read request: the indexed bin's counter is read and returned. Add request: three serial
// divisions by the bin width (2 quotient bits per cycle), then one RAM read-modify-write
// per covered bin. One request at a time. After reset the counter RAM is zeroed, one
// entry per cycle while s_axis_tready is low. Depends on ibc_pkg and ibc_ram.
`timescale 1ns / 1ps

module interval_bin_coverage #(
  parameter int unsigned NUM_BINS    = ibc_pkg::IBC_NUM_BINS_DEF,
  parameter int unsigned COUNT_WIDTH = ibc_pkg::IBC_COUNT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata: interval_start[31:0], interval_end[63:32], bin_index[73:64], zero pad
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ibc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tuser: req_type[0]
  input  logic                             s_axis_tuser,
  // tdata: bin_count[31:0], bins_added[42:32], filtered_out[43], range_clipped[44], pad
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ibc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ibc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ibc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import ibc_pkg::*;

  localparam int unsigned AW   = $clog2(NUM_BINS);
  localparam int unsigned DIVW = 34;   // dividend bits, even for two steps a cycle
  localparam int unsigned SW   = 36;   // signed bin arithmetic
  localparam logic [4:0]  DIV_LAST = 5'(DIVW / 2 - 1);
  localparam logic signed [SW-1:0] NB_S = SW'(NUM_BINS);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_FILT  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_CALC  = 4'd5;
  localparam logic [3:0] S_RANGE = 4'd6;
  localparam logic [3:0] S_BINS  = 4'd7;
  localparam logic [3:0] S_DRAIN = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // Configuration registers
  logic [BIN_SPAN_W-1:0] bin_span_q;
  logic [POS_W-1:0]      first_start_q;
  logic                  filter_on_q;
  logic [POS_W-1:0]      min_length_q;
  logic [POS_W-1:0]      max_length_q;

  logic [3:0] state_q, state_d;

  // Request
  logic [POS_W-1:0]     start_q, start_d;
  logic [POS_W-1:0]     end_q, end_d;
  logic                 rd_clip_q, rd_clip_d;

  // Divider
  logic [1:0]           div_sel_q, div_sel_d;
  logic [4:0]           div_cnt_q, div_cnt_d;
  logic [BIN_SPAN_W-1:0] div_rem_q, div_rem_d;
  logic [DIVW-1:0]      div_quo_q, div_quo_d;
  logic [BIN_SPAN_W-1:0] rem_n;
  logic [DIVW-1:0]      quo_n;
  logic [1:0]           op_sel;
  logic [DIVW-1:0]      div_op;
  logic [BIN_SPAN_W-1:0] bs_eff;
  logic [POS_W-1:0]     end_max;
  logic [POS_W:0]       end_ceil;

  // Quotients: start/bs, first_start/bs, ceil(max(end, start)/bs)
  logic [DIVW-1:0]      qs_q, qs_d, qf_q, qf_d, qc_q, qc_d;
  logic signed [SW-1:0] lo_q, lo_d, hi_q, hi_d, nb_q, nb_d;

  // Bin walk
  logic [AW-1:0]        k_q, k_d;
  logic [AW:0]          bend_q, bend_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        paddr_q, paddr_d;
  logic [AW-1:0]        clr_q, clr_d;

  // Result
  logic [OUT_COUNT_W-1:0] res_count_q, res_count_d;
  logic [ADDED_W-1:0]     res_added_q, res_added_d;
  logic                   res_filt_q, res_filt_d;
  logic                   res_clip_q, res_clip_d;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // RAM
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [COUNT_WIDTH+OUT_COUNT_W-1:0] rdata_ext;

  // Misc comb
  logic                   in_accept;
  logic [AW+BIN_IDX_W-1:0] idx_ext;
  logic [POS_W-1:0]       len;
  logic                   filt;
  logic signed [SW-1:0]   a_s, b_s, added_s;
  logic signed [SW-1:0]   trial;

  ibc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign bs_eff    = (bin_span_q == '0) ? BIN_SPAN_W'(1) : bin_span_q;
  assign end_max   = (end_q >= start_q) ? end_q : start_q;
  assign end_ceil  = {1'b0, end_max} + (POS_W + 1)'(bs_eff) - (POS_W + 1)'(1);
  assign len       = (end_q >= start_q) ? (end_q - start_q) : '0;
  assign filt      = filter_on_q && !((len >= min_length_q) && (len < max_length_q));
  assign idx_ext   = (AW + BIN_IDX_W)'(s_axis_tdata[2*POS_W +: BIN_IDX_W]);
  assign rdata_ext = {{OUT_COUNT_W{1'b0}}, ram_rdata};

  // Dividend select
  assign op_sel = (state_q == S_DIV) ? (div_sel_q + 2'd1) : 2'd0;
  always_comb begin
    case (op_sel)
      2'd0:    div_op = DIVW'(start_q);
      2'd1:    div_op = DIVW'(first_start_q);
      default: div_op = DIVW'(end_ceil);
    endcase
  end

  // Two restoring division steps per cycle
  always_comb begin
    logic [BIN_SPAN_W:0] tr;
    logic [BIN_SPAN_W:0] diff;
    rem_n = div_rem_q;
    quo_n = div_quo_q;
    for (int i = 0; i < 2; i++) begin
      tr    = {rem_n, quo_n[DIVW-1]};
      quo_n = {quo_n[DIVW-2:0], 1'b0};
      diff  = tr - {1'b0, bs_eff};
      if (tr >= {1'b0, bs_eff}) begin
        rem_n    = diff[BIN_SPAN_W-1:0];
        quo_n[0] = 1'b1;
      end else begin
        rem_n = tr[BIN_SPAN_W-1:0];
      end
    end
  end

  // Clip the bin run to the store
  assign a_s     = (lo_q < 0) ? '0 : lo_q;
  assign b_s     = (hi_q > NB_S) ? NB_S : hi_q;
  assign trial   = b_s - a_s;
  assign added_s = (b_s > a_s) ? trial : '0;

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = paddr_q;
    ram_wdata = ram_rdata + COUNT_WIDTH'(1);
    ram_re    = 1'b0;
    ram_raddr = k_q;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_re    = in_accept && (s_axis_tuser == REQ_READ);
        ram_raddr = idx_ext[AW-1:0];
      end
      S_BINS: begin
        ram_re = 1'b1;
        ram_we = pend_q;
      end
      S_DRAIN: begin
        ram_we = pend_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    end_d       = end_q;
    rd_clip_d   = rd_clip_q;
    div_sel_d   = div_sel_q;
    div_cnt_d   = div_cnt_q;
    div_rem_d   = div_rem_q;
    div_quo_d   = div_quo_q;
    qs_d        = qs_q;
    qf_d        = qf_q;
    qc_d        = qc_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    nb_d        = nb_q;
    k_d         = k_q;
    bend_d      = bend_q;
    pend_d      = pend_q;
    paddr_d     = paddr_q;
    clr_d       = clr_q;
    res_count_d = res_count_q;
    res_added_d = res_added_q;
    res_filt_d  = res_filt_q;
    res_clip_d  = res_clip_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(NUM_BINS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          start_d   = s_axis_tdata[POS_W-1:0];
          end_d     = s_axis_tdata[2*POS_W-1:POS_W];
          rd_clip_d = (32'(s_axis_tdata[2*POS_W +: BIN_IDX_W]) >= 32'(NUM_BINS));
          state_d   = (s_axis_tuser == REQ_READ) ? S_READ : S_FILT;
        end
      end
      S_READ: begin
        res_count_d = rd_clip_q ? '0 : rdata_ext[OUT_COUNT_W-1:0];
        res_added_d = '0;
        res_filt_d  = 1'b0;
        res_clip_d  = rd_clip_q;
        state_d     = S_DONE;
      end
      S_FILT: begin
        res_count_d = '0;
        res_added_d = '0;
        res_filt_d  = filt;
        res_clip_d  = 1'b0;
        if (filt) begin
          state_d = S_DONE;
        end else begin
          div_sel_d = 2'd0;
          div_cnt_d = '0;
          div_rem_d = '0;
          div_quo_d = div_op;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        div_cnt_d = div_cnt_q + 5'd1;
        div_rem_d = rem_n;
        div_quo_d = quo_n;
        if (div_cnt_q == DIV_LAST) begin
          case (div_sel_q)
            2'd0:    qs_d = quo_n;
            2'd1:    qf_d = quo_n;
            default: qc_d = quo_n;
          endcase
          div_cnt_d = '0;
          div_rem_d = '0;
          div_quo_d = div_op;
          div_sel_d = div_sel_q + 2'd1;
          if (div_sel_q == 2'd2) begin
            state_d = S_CALC;
          end
        end
      end
      S_CALC: begin
        lo_d    = SW'(qs_q) - SW'(qf_q);
        hi_d    = SW'(qc_q) - SW'(qf_q);
        nb_d    = SW'(qc_q) - SW'(qs_q);
        state_d = S_RANGE;
      end
      S_RANGE: begin
        res_added_d = added_s[ADDED_W-1:0];
        res_clip_d  = (added_s != nb_q);
        k_d         = a_s[AW-1:0];
        bend_d      = b_s[AW:0];
        pend_d      = 1'b0;
        state_d     = (b_s > a_s) ? S_BINS : S_DONE;
      end
      S_BINS: begin
        // read bin k while bin k-1 is written back
        pend_d  = 1'b1;
        paddr_d = k_q;
        k_d     = k_q + AW'(1);
        if (({1'b0, k_q} + (AW + 1)'(1)) == bend_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        pend_d  = 1'b0;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = OUT_TDATA_W'({res_clip_q, res_filt_q, res_added_q, res_count_q});
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_q         <= '0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      bin_span_q    <= BIN_SPAN_RST;
      first_start_q <= '0;
      filter_on_q   <= 1'b0;
      min_length_q  <= '0;
      max_length_q  <= MAX_LENGTH_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_BIN_SPAN:    bin_span_q    <= cfg_data_i[BIN_SPAN_W-1:0];
          REG_FIRST_START: first_start_q <= cfg_data_i;
          REG_FILTER_ON:   filter_on_q   <= cfg_data_i[0];
          REG_MIN_LENGTH:  min_length_q  <= cfg_data_i;
          REG_MAX_LENGTH:  max_length_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    end_q       <= end_d;
    rd_clip_q   <= rd_clip_d;
    div_sel_q   <= div_sel_d;
    div_cnt_q   <= div_cnt_d;
    div_rem_q   <= div_rem_d;
    div_quo_q   <= div_quo_d;
    qs_q        <= qs_d;
    qf_q        <= qf_d;
    qc_q        <= qc_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    nb_q        <= nb_d;
    k_q         <= k_d;
    bend_q      <= bend_d;
    paddr_q     <= paddr_d;
    res_count_q <= res_count_d;
    res_added_q <= res_added_d;
    res_filt_q  <= res_filt_d;
    res_clip_q  <= res_clip_d;
    out_data_q  <= out_data_d;
  end

endmodule

// File: src/ibc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ibc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for interval_bin_coverage: directed and random add/read
// requests, random stalls on both streams, results checked against a coverage predictor.
// Depends on ibc_pkg and the interval_bin_coverage RTL.
`timescale 1ns / 1ps

module tb;
  import ibc_pkg::*;

  localparam int unsigned NUM_BINS = IBC_NUM_BINS_DEF;
  // Covers the longest add, the counter clear after reset and stalls on either
  // side; taken many times over.
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct {
    bit        req_type;
    bit [31:0] start_pos;
    bit [31:0] end_pos;
    bit [9:0]  bin_index;
  } request_t;

  typedef struct {
    bit [31:0] bin_count;
    bit [10:0] bins_added;
    bit        filtered_out;
    bit        range_clipped;
  } result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  // Shadow of the block's registers and counter store
  bit [20:0] cfg_bin_span    = BIN_SPAN_RST;
  bit [31:0] cfg_first_start = '0;
  bit        cfg_filter_on   = 1'b0;
  bit [31:0] cfg_min_len     = '0;
  bit [31:0] cfg_max_len     = MAX_LENGTH_RST;
  bit [31:0] bin_hits [NUM_BINS];

  result_t     pending_results [$];
  int          err_cnt = 0;
  int          src_idle_pct = 36;
  int          sink_idle_pct = 36;
  int unsigned stall_cycles = 0;

  interval_bin_coverage i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Applies one request to the shadow store and returns the response it must give
  function automatic result_t compute_bin_response(request_t rq);
    result_t         r;
    longint unsigned bs, s, e, len;
    longint          lo, nb, hi, a, b;
    r = '{default: '0};
    if (rq.req_type == REQ_READ) begin
      if (rq.bin_index < NUM_BINS) r.bin_count = bin_hits[rq.bin_index];
      else r.range_clipped = 1'b1;
    end else begin
      bs  = (cfg_bin_span == 0) ? 1 : cfg_bin_span;
      s   = rq.start_pos;
      e   = rq.end_pos;
      len = (e >= s) ? e - s : 0;
      if (cfg_filter_on && !(len >= cfg_min_len && len < cfg_max_len)) begin
        r.filtered_out = 1'b1;
      end else begin
        lo = longint'(s / bs) - longint'(cfg_first_start / bs);
        nb = longint'(((s % bs) + len + bs - 1) / bs);
        hi = lo + nb;
        a  = (lo < 0) ? 0 : lo;
        b  = (hi > longint'(NUM_BINS)) ? longint'(NUM_BINS) : hi;
        if (b > a) begin
          for (longint k = a; k < b; k++) bin_hits[k] = bin_hits[k] + 1;
          r.bins_added = 11'(b - a);
        end
        if (((b > a) ? b - a : 0) != nb) r.range_clipped = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input bit [31:0] want, input bit [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Result checker and random back-pressure on the master side
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.bin_count     = m_axis_tdata[31:0];
      got.bins_added    = m_axis_tdata[42:32];
      got.filtered_out  = m_axis_tdata[43];
      got.range_clipped = m_axis_tdata[44];
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, actual 0x%0h",
                 $time, m_axis_tdata);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("bin_count", want.bin_count, got.bin_count);
        check_field("bins_added", 32'(want.bins_added), 32'(got.bins_added));
        check_field("filtered_out", 32'(want.filtered_out), 32'(got.filtered_out));
        check_field("range_clipped", 32'(want.range_clipped), 32'(got.range_clipped));
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("%0t ns: timeout, no beat accepted for %0d cycles", $time, STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Leaves tvalid high after the beat, so back-to-back requests toggle it only when random source idling is drawn
  task automatic send_request(input request_t rq);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, rq.bin_index, rq.end_pos, rq.start_pos};
    s_axis_tuser  <= rq.req_type;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(compute_bin_response(rq));
  endtask

  task automatic send_add(input bit [31:0] start_pos, input bit [31:0] end_pos);
    request_t rq;
    rq = '{req_type: REQ_ADD, start_pos: start_pos, end_pos: end_pos,
           bin_index: 10'($urandom)};
    send_request(rq);
  endtask

  task automatic send_read(input bit [9:0] bin_index);
    request_t rq;
    rq = '{req_type: REQ_READ, start_pos: $urandom, end_pos: $urandom, bin_index: bin_index};
    send_request(rq);
  endtask

  // Drop tvalid and let every outstanding response come back before touching registers
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_BIN_SPAN:    cfg_bin_span    = val[20:0];
      REG_FIRST_START: cfg_first_start = val;
      REG_FILTER_ON:   cfg_filter_on   = val[0];
      REG_MIN_LENGTH:  cfg_min_len     = val;
      REG_MAX_LENGTH:  cfg_max_len     = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic test_after_reset();
    send_read(10'd0);
    send_read(10'd1023);
  endtask

  task automatic test_default_bins();
    send_add(32'd0, 32'd0);                  // empty, on a bin edge: no bins
    send_add(32'd999, 32'd999);              // empty, mid-bin: one bin
    send_add(32'd1500, 32'd3200);
    send_add(32'd5000, 32'd10);              // end before start
    send_add(32'd0, 32'hFFFF_FFFF);          // whole store plus overflow
    send_add(32'hFFFF_FFFF, 32'hFFFF_FFFF);  // far above the store
    send_read(10'd0);
    send_read(10'd1);
  endtask

  task automatic test_bin_span_extremes();
    wait_drained();
    write_reg(REG_BIN_SPAN, 32'd0);          // behaves as size one
    write_reg(REG_FIRST_START, 32'd100);
    send_add(32'd100, 32'd105);
    send_add(32'd50, 32'd102);               // starts below bin zero
    send_read(10'd3);
    wait_drained();
    write_reg(REG_BIN_SPAN, 32'd1048576);
    write_reg(REG_FIRST_START, 32'hFFFF_FFFF);
    send_add(32'hFFF0_0000, 32'hFFFF_FFFF);
    send_add(32'd1048575, 32'd3145728);
    send_read(10'd0);
  endtask

  task automatic test_length_filter();
    wait_drained();
    write_reg(REG_BIN_SPAN, 32'd16);
    write_reg(REG_FIRST_START, 32'd0);
    write_reg(REG_FILTER_ON, 32'd1);
    write_reg(REG_MIN_LENGTH, 32'd10);
    write_reg(REG_MAX_LENGTH, 32'd20);
    send_add(32'd32, 32'd41);
    send_add(32'd32, 32'd42);
    send_add(32'd32, 32'd51);
    send_add(32'd32, 32'd52);
    wait_drained();
    write_reg(REG_MIN_LENGTH, 32'd0);
    write_reg(REG_MAX_LENGTH, 32'hFFFF_FFFF);
    send_add(32'd0, 32'hFFFF_FFFF);          // max length is exclusive
    send_add(32'd7, 32'd7);
    wait_drained();
    write_reg(REG_MAX_LENGTH, 32'd0);        // empty window rejects everything
    send_add(32'd64, 32'd70);
  endtask

  task automatic set_random_config();
    bit [31:0]   bs, min_len;
    int unsigned pick;
    pick = $urandom_range(5);
    case (pick)
      0: bs = 1;
      1: bs = $urandom_range(2, 16);
      2: bs = 1000;
      3: bs = $urandom_range(17, 5000);
      4: bs = 1048576;
      default: bs = 0;
    endcase
    min_len = $urandom_range(2 * ((bs == 0) ? 1 : bs));
    write_reg(REG_BIN_SPAN, bs);
    write_reg(REG_FIRST_START, $urandom_range(1) ? $urandom : $urandom_range(10000));
    write_reg(REG_FILTER_ON, 32'($urandom_range(2) == 0));
    write_reg(REG_MIN_LENGTH, min_len);
    write_reg(REG_MAX_LENGTH, min_len + $urandom_range(1, 6 * ((bs == 0) ? 1 : bs)));
  endtask

  // Mostly intervals that land in or near the store, the rest reads and noise
  task automatic run_random_phase(input int n_items);
    request_t    rq;
    int unsigned bs, off, len, roll;
    for (int i = 0; i < n_items; i++) begin
      bs   = (cfg_bin_span == 0) ? 1 : cfg_bin_span;
      roll = $urandom_range(99);
      rq.req_type  = REQ_ADD;
      rq.bin_index = 10'($urandom);
      rq.start_pos = $urandom;
      rq.end_pos   = $urandom;
      if (roll < 30) begin
        rq.req_type = REQ_READ;
      end else if (roll < 88) begin
        off = $urandom_range(NUM_BINS * bs + 2 * bs);
        len = ($urandom_range(9) == 0) ? $urandom_range(64 * bs) : $urandom_range(4 * bs);
        rq.start_pos = cfg_first_start + off;
        rq.end_pos   = rq.start_pos + len;
      end else if (roll < 94) begin
        rq.end_pos = rq.start_pos - $urandom_range(3000);
      end
      send_request(rq);
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      set_random_config();
      // one phase runs with no idling on either stream
      src_idle_pct  = (phase == 2) ? 0 : 36;
      sink_idle_pct = (phase == 2) ? 0 : 36;
      run_random_phase(115);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_after_reset();
    test_default_bins();
    test_bin_span_extremes();
    test_length_filter();
    test_random_traffic();
    wait_drained();
    repeat (64) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ibc_pkg.sv
src/ibc_ram.sv
src/interval_bin_coverage.sv
tb/sv/tb.sv
